// ===== sv/rfv_pkg.sv =====
`timescale 1ns / 1ps
package rfv_pkg;

  localparam int STORE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int REL_W       = FILL_W + 1;
  localparam int SUM_W       = REL_W + 1;
  localparam int MAX_EVENTS  = 64;
  localparam int EVC_W       = $clog2(MAX_EVENTS + 2);
  localparam int CFG_W       = 10;

  // crc-24q polynomial 0x1864cfb without its top bit
  localparam logic [23:0] CRC_POLY     = 24'h864CFB;
  localparam logic [7:0]  RSV_MASK     = 8'hFC;
  localparam logic [7:0]  LEN_HI_MASK  = 8'h03;
  localparam logic [7:0]  PREAMBLE_RST = 8'hD3;
  localparam logic [9:0]  MAXLEN_RST   = 10'h3FF;

  localparam logic REG_PREAMBLE = 1'b0;
  localparam logic REG_MAXLEN   = 1'b1;

  // read offset select
  localparam logic [1:0] RD_OFF0 = 2'd0;
  localparam logic [1:0] RD_OFF1 = 2'd1;
  localparam logic [1:0] RD_OFF2 = 2'd2;
  localparam logic [1:0] RD_NEXT = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [11:0] mtype;
    logic [9:0]  len;
    logic        ovf;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       pos_inc;
    logic       pos_frame;
    logic       pos_size;
    logic       lat_b1;
    logic       lat_len;
    logic       crc_init;
    logic       crc_step;
    logic       emit;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic pos_ge_size;
    logic match;
    logic hdr_short;
    logic b1_bad;
    logic len_bad;
    logic frame_short;
    logic crc_last;
    logic crc_ok;
    logic emit_ok;
    logic done_ok;
  } sts_t;

  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] d);
    logic [23:0] c;
    c = crc ^ {d, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      c = c[23] ? ({c[22:0], 1'b0} ^ CRC_POLY) : {c[22:0], 1'b0};
    end
    return c;
  endfunction

  // circular store address, wraps once, so the sum of both operands must stay below twice STORE_DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [REL_W-1:0] rel);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(rel);
    if (s >= SUM_W'(STORE_DEPTH)) begin
      s = s - SUM_W'(STORE_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ===== sv/rfv_ram.sv =====
`timescale 1ns / 1ps
module rfv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rfv_ctrl.sv =====
`timescale 1ns / 1ps
module rfv_ctrl import rfv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HUNT   = 3'd1;
  localparam logic [2:0] S_HUNT_W = 3'd2;
  localparam logic [2:0] S_B1     = 3'd3;
  localparam logic [2:0] S_B2     = 3'd4;
  localparam logic [2:0] S_CRC    = 3'd5;
  localparam logic [2:0] S_CHECK  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_OFF0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_HUNT;
        end
      end
      S_HUNT: begin
        if (sts_i.pos_ge_size) begin
          cmd_o.pos_size = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_OFF0;
          state_d = S_HUNT_W;
        end
      end
      S_HUNT_W: begin
        if (!sts_i.match) begin
          cmd_o.pos_inc = 1'b1;
          state_d = S_HUNT;
        end else if (sts_i.hdr_short) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_OFF1;
          state_d = S_B1;
        end
      end
      S_B1: begin
        cmd_o.lat_b1 = 1'b1;
        if (sts_i.b1_bad) begin
          cmd_o.pos_inc = 1'b1;
          state_d = S_HUNT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_OFF2;
          state_d = S_B2;
        end
      end
      S_B2: begin
        cmd_o.lat_len = 1'b1;
        if (sts_i.len_bad) begin
          cmd_o.pos_inc = 1'b1;
          state_d = S_HUNT;
        end else if (sts_i.frame_short) begin
          state_d = S_DONE;
        end else begin
          cmd_o.crc_init = 1'b1;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_OFF0;
          state_d = S_CRC;
        end
      end
      S_CRC: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.crc_last) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
        end
      end
      S_CHECK: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.crc_ok) begin
            cmd_o.pos_frame = 1'b1;
          end else begin
            cmd_o.pos_inc = 1'b1;
          end
          state_d = S_HUNT;
        end
      end
      S_DONE: begin
        if (sts_i.done_ok) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ap_emit_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.emit_ok) else $error("emit while event slots full");
  ap_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_HUNT) else $error("accept did not start a scan");
  ap_crc_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC && sts_i.crc_last) |=> state_q == S_CHECK)
    else $error("crc walk did not end in check");

endmodule

// ===== sv/rfv_dp.sv =====
`timescale 1ns / 1ps
module rfv_dp import rfv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [7:0]       data_byte_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output evt_t             out_o
);

  logic [7:0]        preamble_q;
  logic [9:0]        maxlen_q;
  logic [ADDR_W-1:0] head_q;
  logic [FILL_W-1:0] fill_q;
  logic [REL_W-1:0]  pos_q;
  logic [REL_W-1:0]  cnt_q;
  logic [1:0]        b1_q;
  logic [9:0]        len_q;
  logic [23:0]       crc_q;
  logic [23:0]       exp_q;
  logic [11:0]       mt_q;
  logic [EVC_W-1:0]  evc_q;
  evt_t              pend_q;
  logic              pend_v_q;
  evt_t              out_q;
  logic              out_valid_q;

  logic [7:0]        rdata;
  logic [REL_W-1:0]  rel;
  logic [REL_W-1:0]  fill_ext;
  logic [REL_W-1:0]  len_ext;
  logic [9:0]        len_now;
  logic [7:0]        b1_hi;
  logic              store_full;
  logic              crc_ok;
  evt_t              new_evt;

  assign fill_ext   = REL_W'(fill_q);
  assign len_ext    = REL_W'(len_q);
  assign b1_hi      = rdata & LEN_HI_MASK;
  assign len_now    = {b1_q, rdata};
  assign store_full = fill_q == FILL_W'(STORE_DEPTH);
  assign crc_ok     = crc_q == exp_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_OFF1: rel = pos_q + REL_W'(1);
      RD_OFF2: rel = pos_q + REL_W'(2);
      RD_NEXT: rel = pos_q + cnt_q + REL_W'(1);
      default: rel = pos_q;
    endcase
  end

  rfv_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && !store_full),
    .waddr_i(wrap_add(head_q, REL_W'(fill_q))),
    .wdata_i(data_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(wrap_add(head_q, rel)),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.pos_ge_size = pos_q >= fill_ext;
    sts_o.match       = rdata == preamble_q;
    sts_o.hdr_short   = (pos_q + REL_W'(3)) > fill_ext;
    sts_o.b1_bad      = (rdata & RSV_MASK) != 8'h00;
    sts_o.len_bad     = len_now > maxlen_q;
    sts_o.frame_short = (pos_q + REL_W'(len_now) + REL_W'(6)) > fill_ext;
    sts_o.crc_last    = cnt_q == (len_ext + REL_W'(5));
    sts_o.crc_ok      = crc_ok;
    sts_o.emit_ok     = !pend_v_q || !out_valid_q || (evc_q >= EVC_W'(MAX_EVENTS));
    sts_o.done_ok     = !pend_v_q || !out_valid_q;
  end

  always_comb begin
    new_evt.kind  = !crc_ok;
    new_evt.mtype = (crc_ok && len_q >= 10'd2) ? mt_q : 12'h000;
    new_evt.len   = len_q;
    new_evt.ovf   = 1'b0;
    new_evt.last  = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q  <= PREAMBLE_RST;
      maxlen_q    <= MAXLEN_RST;
      head_q      <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      evc_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PREAMBLE: preamble_q <= cfg_data_i[7:0];
          REG_MAXLEN:   maxlen_q   <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.accept) begin
        if (!store_full) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        pos_q <= '0;
        evc_q <= '0;
      end
      if (cmd_i.pos_inc) begin
        pos_q <= pos_q + REL_W'(1);
      end
      if (cmd_i.pos_frame) begin
        pos_q <= pos_q + len_ext + REL_W'(6);
      end
      if (cmd_i.pos_size) begin
        pos_q <= fill_ext;
      end
      if (cmd_i.emit) begin
        if (evc_q < EVC_W'(MAX_EVENTS)) begin
          if (pend_v_q) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
          end
          pend_q   <= new_evt;
          pend_v_q <= 1'b1;
          evc_q    <= evc_q + EVC_W'(1);
        end else if (evc_q == EVC_W'(MAX_EVENTS)) begin
          // later events of this word are dropped
          pend_q.ovf <= 1'b1;
          evc_q      <= evc_q + EVC_W'(1);
        end
      end
      if (cmd_i.finish) begin
        if (pend_v_q) begin
          // last flag is the low bit of the event
          out_q       <= {pend_q[$bits(evt_t)-1:1], 1'b1};
          out_valid_q <= 1'b1;
          pend_v_q    <= 1'b0;
        end
        head_q <= wrap_add(head_q, pos_q);
        fill_q <= fill_q - pos_q[FILL_W-1:0];
        pos_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_b1) begin
      b1_q <= b1_hi[1:0];
    end
    if (cmd_i.lat_len) begin
      len_q <= len_now;
    end
    if (cmd_i.crc_init) begin
      crc_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.crc_step) begin
      if (cnt_q < len_ext + REL_W'(3)) begin
        crc_q <= crc24q_byte(crc_q, rdata);
      end else begin
        exp_q <= {exp_q[15:0], rdata};
      end
      if (cnt_q == REL_W'(3)) begin
        mt_q[11:4] <= rdata;
      end
      if (cnt_q == REL_W'(4)) begin
        mt_q[3:0] <= rdata[7:4];
      end
      cnt_q <= cnt_q + REL_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  ap_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(STORE_DEPTH)) else $error("store fill beyond depth");
  ap_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= fill_ext) else $error("scan position beyond fill");
  ap_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.ovf) |-> out_q.last) else $error("overflow on non-last event");

endmodule

// ===== sv/rtcm3_frame_validator_top.sv =====
`timescale 1ns / 1ps
// each accepted word starts a scan of the buffered bytes; a new word is taken only once that scan ends
// the hunt steps through the stored bytes one at a time, a completed frame adds a CRC walk over its bytes
// a rejected preamble rescans the buffered bytes from the next byte on; a full output stalls
// reset: asynchronous active low, empties the store and restores both registers
module rtcm3_frame_validator_top import rfv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             event_kind_o,
  output logic [11:0]      message_type_o,
  output logic [9:0]       payload_length_o,
  output logic             event_overflow_o,
  output logic             last_event_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  evt_t evt;

  rfv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rfv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .data_byte_i(data_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (evt)
  );

  assign event_kind_o     = evt.kind;
  assign message_type_o   = evt.mtype;
  assign payload_length_o = evt.len;
  assign event_overflow_o = evt.ovf;
  assign last_event_o     = evt.last;

endmodule
